@@ rtl/amc_pkg.sv @@
`default_nettype none

package amc_pkg;

   localparam int DIM   = 3;
   localparam int CELLS = DIM * DIM;
   localparam int IDX_W = $clog2(CELLS);
   localparam int PC_W  = 6;

   // Program layout of the sequencer
   localparam int PC_DISPATCH_ID   = 0;
   localparam int PC_DISPATCH_KEEP = 1;
   localparam int PC_MAC0          = 2;
   localparam int PC_DRAIN         = PC_MAC0 + CELLS * DIM;
   localparam int PC_COMMIT        = PC_DRAIN + 1;
   localparam int PC_IDENT         = PC_COMMIT + 1;
   localparam int PC_EMIT          = PC_IDENT + 1;

   typedef logic signed [31:0] word_type;
   typedef word_type mat_type [CELLS];

   localparam word_type Q_ONE    = 32'sh0001_0000;
   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      OP_IDENTITY = 2'd0,
      OP_PRE      = 2'd1,
      OP_POST     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic             load;
      logic             pre;
      logic             mac;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] dst;
      logic             commit;
      logic             ident;
      logic             emit;
   } ctl_type;

endpackage

`default_nettype wire

@@ rtl/affine_matrix_composer_3x3.sv @@
`default_nettype none

// A multiply item runs its product terms, a drain step, a commit and an emit;
// identity load runs an identity step and an emit, the unused operation code only an emit.
// A new item is taken only while idle; the shared 32x32 multiplier
// and accumulator walk the 27 product terms one per step of the program.
// Reset (synchronous, active high) sets the stored matrix to identity and
// clears the result valid flag.
module affine_matrix_composer_3x3
   import amc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic signed [31:0] req_arg_r0c0,
   input  wire logic signed [31:0] req_arg_r0c1,
   input  wire logic signed [31:0] req_arg_r0c2,
   input  wire logic signed [31:0] req_arg_r1c0,
   input  wire logic signed [31:0] req_arg_r1c1,
   input  wire logic signed [31:0] req_arg_r1c2,
   input  wire logic signed [31:0] req_arg_r2c0,
   input  wire logic signed [31:0] req_arg_r2c1,
   input  wire logic signed [31:0] req_arg_r2c2,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_cur_r0c0,
   output logic signed [31:0] rsp_cur_r0c1,
   output logic signed [31:0] rsp_cur_r0c2,
   output logic signed [31:0] rsp_cur_r1c0,
   output logic signed [31:0] rsp_cur_r1c1,
   output logic signed [31:0] rsp_cur_r1c2,
   output logic signed [31:0] rsp_cur_r2c0,
   output logic signed [31:0] rsp_cur_r2c1,
   output logic signed [31:0] rsp_cur_r2c2
);

   ctl_type ctl;
   mat_type arg_in;
   mat_type rsp_mat;

   assign arg_in[0] = req_arg_r0c0;
   assign arg_in[1] = req_arg_r0c1;
   assign arg_in[2] = req_arg_r0c2;
   assign arg_in[3] = req_arg_r1c0;
   assign arg_in[4] = req_arg_r1c1;
   assign arg_in[5] = req_arg_r1c2;
   assign arg_in[6] = req_arg_r2c0;
   assign arg_in[7] = req_arg_r2c1;
   assign arg_in[8] = req_arg_r2c2;

   amc_sequencer u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .ctl           (ctl)
   );

   amc_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .arg_in  (arg_in),
      .rsp_mat (rsp_mat)
   );

   assign rsp_cur_r0c0 = rsp_mat[0];
   assign rsp_cur_r0c1 = rsp_mat[1];
   assign rsp_cur_r0c2 = rsp_mat[2];
   assign rsp_cur_r1c0 = rsp_mat[3];
   assign rsp_cur_r1c1 = rsp_mat[4];
   assign rsp_cur_r1c2 = rsp_mat[5];
   assign rsp_cur_r2c0 = rsp_mat[6];
   assign rsp_cur_r2c1 = rsp_mat[7];
   assign rsp_cur_r2c2 = rsp_mat[8];

endmodule

`default_nettype wire

@@ rtl/amc_sequencer.sv @@
`default_nettype none

module amc_sequencer
   import amc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output ctl_type         ctl
);

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_MAC,
      CMD_COMMIT,
      CMD_IDENT,
      CMD_EMIT
   } cmd_type;

   typedef enum logic [1:0] {
      J_NEXT,
      J_IDENT,
      J_KEEP,
      J_ALWAYS
   } jump_type;

   typedef struct packed {
      cmd_type          cmd;
      jump_type         cond;
      logic [PC_W-1:0]  target;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] dst;
   } uword_type;

   typedef enum logic {
      S_IDLE,
      S_RUN
   } state_type;

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{cmd: CMD_NOP, cond: J_NEXT, target: '0, left: '0, right: '0,
            first: 1'b0, last: 1'b0, dst: '0};
      case (pc)
         PC_W'(PC_DISPATCH_ID): begin
            w.cond   = J_IDENT;
            w.target = PC_W'(PC_IDENT);
         end
         PC_W'(PC_DISPATCH_KEEP): begin
            w.cond   = J_KEEP;
            w.target = PC_W'(PC_EMIT);
         end
         PC_W'(PC_COMMIT): begin
            w.cmd    = CMD_COMMIT;
            w.cond   = J_ALWAYS;
            w.target = PC_W'(PC_EMIT);
         end
         PC_W'(PC_IDENT): begin
            w.cmd = CMD_IDENT;
         end
         PC_W'(PC_EMIT): begin
            w.cmd = CMD_EMIT;
         end
         default: begin
            w.cmd = CMD_NOP;
         end
      endcase
      // One multiply-accumulate step per term, row-major over the result
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            for (int k = 0; k < DIM; k++) begin
               if (pc == PC_W'(PC_MAC0 + (r * DIM + c) * DIM + k)) begin
                  w.cmd   = CMD_MAC;
                  w.left  = IDX_W'(r * DIM + k);
                  w.right = IDX_W'(k * DIM + c);
                  w.first = (k == 0);
                  w.last  = (k == DIM - 1);
                  w.dst   = IDX_W'(r * DIM + c);
               end
            end
         end
      end
      return w;
   endfunction

   state_type       state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   op_type          op_ff, op_in;
   logic            rsp_valid_ff, rsp_valid_in;

   uword_type uw;
   logic      accept;
   logic      out_held;
   logic      take_jump;
   logic      emit_go;

   always_comb begin
      uw        = ucode_rom(pc_ff);
      accept    = req_valid && (state_ff == S_IDLE);
      out_held  = rsp_valid_ff && rsp_stall;
      emit_go   = (state_ff == S_RUN) && (uw.cmd == CMD_EMIT) && !out_held;
      take_jump = (uw.cond == J_ALWAYS) ||
                  ((uw.cond == J_IDENT) && (op_ff == OP_IDENTITY)) ||
                  ((uw.cond == J_KEEP) && (op_ff == OP_NONE));

      state_in     = state_ff;
      pc_in        = pc_ff;
      op_in        = op_ff;
      rsp_valid_in = emit_go ? 1'b1 : out_held;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RUN;
               pc_in    = '0;
               op_in    = op_type'(req_operation);
            end
         end
         S_RUN: begin
            if (uw.cmd == CMD_EMIT) begin
               // hold on the emit step until the output register frees up
               if (emit_go) begin
                  state_in = S_IDLE;
               end
            end else if (take_jump) begin
               pc_in = uw.target;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         op_ff        <= OP_IDENTITY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      req_stall  = (state_ff != S_IDLE);
      rsp_valid  = rsp_valid_ff;
      ctl.load   = accept;
      ctl.pre    = (op_ff == OP_PRE);
      ctl.mac    = (state_ff == S_RUN) && (uw.cmd == CMD_MAC);
      ctl.left   = uw.left;
      ctl.right  = uw.right;
      ctl.first  = uw.first;
      ctl.last   = uw.last;
      ctl.dst    = uw.dst;
      ctl.commit = (state_ff == S_RUN) && (uw.cmd == CMD_COMMIT);
      ctl.ident  = (state_ff == S_RUN) && (uw.cmd == CMD_IDENT);
      ctl.emit   = emit_go;
   end

`ifndef NO_ASSERTIONS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sequencer not busy after a transfer in");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> !(rsp_valid && rsp_stall))
      else $error("emit overwrote a stalled result");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl.emit))
      else $error("result valid without an emit step");

   a_mac_running: assert property (@(posedge clock) disable iff (reset)
      ctl.mac || ctl.commit || ctl.ident |-> req_stall)
      else $error("datapath step issued while idle");
`endif

endmodule

`default_nettype wire

@@ rtl/amc_datapath.sv @@
`default_nettype none

module amc_datapath
   import amc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire ctl_type ctl,
   input  wire mat_type arg_in,
   output mat_type      rsp_mat
);

   localparam int ACC_W  = 50;
   localparam int TERM_W = 48;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(WORD_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(WORD_MIN);

   mat_type arg_ff;
   mat_type cur_ff;
   mat_type tmp_ff;
   mat_type rsp_ff;

   logic signed [63:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    s2_mac_ff;
   logic                    s2_first_ff;
   logic                    s2_last_ff;
   logic [IDX_W-1:0]        s2_dst_ff;

   word_type                 lhs, rhs;
   logic signed [TERM_W-1:0] term;
   word_type                 sat_word;

   always_comb begin
      lhs     = ctl.pre ? arg_ff[ctl.left] : cur_ff[ctl.left];
      rhs     = ctl.pre ? cur_ff[ctl.right] : arg_ff[ctl.right];
      prod_in = lhs * rhs;

      // arithmetic shift of the Q32.32 product floors to Q32.16
      term   = prod_ff[63:16];
      acc_in = (s2_first_ff ? '0 : acc_ff) + ACC_W'(term);

      if (acc_in > SAT_HI) begin
         sat_word = WORD_MAX;
      end else if (acc_in < SAT_LO) begin
         sat_word = WORD_MIN;
      end else begin
         sat_word = acc_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mac_ff <= 1'b0;
         for (int i = 0; i < CELLS; i++) begin
            cur_ff[i] <= (i % (DIM + 1) == 0) ? Q_ONE : '0;
         end
      end else begin
         s2_mac_ff <= ctl.mac;
         if (ctl.commit) begin
            cur_ff <= tmp_ff;
         end else if (ctl.ident) begin
            for (int i = 0; i < CELLS; i++) begin
               cur_ff[i] <= (i % (DIM + 1) == 0) ? Q_ONE : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         arg_ff <= arg_in;
      end
      prod_ff     <= prod_in;
      s2_first_ff <= ctl.first;
      s2_last_ff  <= ctl.last;
      s2_dst_ff   <= ctl.dst;
      if (s2_mac_ff) begin
         acc_ff <= acc_in;
         if (s2_last_ff) begin
            tmp_ff[s2_dst_ff] <= sat_word;
         end
      end
      if (ctl.emit) begin
         rsp_ff <= cur_ff;
      end
   end

   assign rsp_mat = rsp_ff;

endmodule

`default_nettype wire
